@@ hw/rtl/m4inv_pkg.sv @@
// Package for the 4x4 fixed-point matrix inverse.
// Widths, defaults and the index helper used by the cofactor sequencer.
// No dependencies.
package m4inv_pkg;

  localparam int ELEM_W       = 32;
  localparam int THR_W        = 16;
  localparam int FRAC_BITS_DF = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  // Minor row/column lists: the three indices other than the skipped one
  function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] k);
    logic [1:0] v;
    begin
      v = k;
      if (k >= skip) v = k + 2'd1;
      return v;
    end
  endfunction

endpackage

@@ hw/rtl/m4inv_if.sv @@
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
interface m4inv_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/matrix4_inverse.sv @@
// 4x4 matrix inverse by adjugate, signed fixed point.
// Depends on m4inv_pkg.
//
// Usage: send four rows on in_* (valid/ready); the request with final_row
// set stores its row and starts the inversion. The block then holds
// in_ready low until all four result rows have been taken on out_*.
// cfg_* writes singular_threshold (reset value 1); the user must write it
// only while idle: the block itself does not enforce it. Non-final rows
// may follow back to back. For the final row, each of the 16 cofactors
// takes three 2x2 minors of two products and three scalings of two limb
// steps through the one 32x32 multiplier, plus one sign step; then come 12
// determinant steps and one threshold compare. Each inverse element then
// takes setup, 192 quotient bits (one a cycle in the shared restoring
// divider) and rounding; a singular matrix skips the division.
// Each output row is registered; while the receiver stalls, out_valid
// holds and the sequencer waits.
// Reset (synchronous, rst_n low) clears row count, sequencer and threshold.
module matrix4_inverse
  import m4inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [ELEM_W-1:0] in_elem_x,
  input  logic signed [ELEM_W-1:0] in_elem_y,
  input  logic signed [ELEM_W-1:0] in_elem_z,
  input  logic signed [ELEM_W-1:0] in_elem_w,
  input  logic in_final_row,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [ELEM_W-1:0] out_inv_x,
  output logic signed [ELEM_W-1:0] out_inv_y,
  output logic signed [ELEM_W-1:0] out_inv_z,
  output logic signed [ELEM_W-1:0] out_inv_w,
  output logic out_singular,
  output logic out_last_row,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int WW   = 192;              // wide accumulator
  localparam int DW   = WW - 2*FRAC_BITS; // dividend magnitude bits kept
  localparam int QB   = DW + 2*FRAC_BITS; // quotient steps
  localparam int QCW  = $clog2(QB + 1);
  localparam int LW   = 32;               // multiplier limb width

  typedef enum logic [3:0] {
    S_LOAD, S_COF_M, S_COF_S, S_COF_N, S_DET, S_THR,
    S_DIV_INIT, S_DIV, S_DIV_RND, S_EMIT
  } state_t;

  state_t state_r;
  logic [1:0]  row_cnt_r;
  logic [THR_W-1:0] thr_r;
  logic signed [ELEM_W-1:0] mat_r [16];
  logic signed [WW-1:0] cof_r [16];
  logic signed [WW-1:0] acc_r, minor_r, det_r;
  logic [3:0]  cidx_r;                // cofactor index r*4+c
  logic [1:0]  term_r;                // which 3x3 term
  logic [1:0]  mstep_r;               // 2x2 product step
  logic [1:0]  mlimb_r;               // limb of the wide operand
  logic [1:0]  orow_r, ocol_r;
  logic        sing_r;
  logic [WW-1:0] dmag_r, rem_r, qt_r;
  logic        dneg_r;
  logic [QCW-1:0] bit_r;
  logic signed [ELEM_W-1:0] rowbuf_r [4];

  // Single shared 32x32 unsigned multiplier: the wide operand is taken one
  // 32-bit limb of its magnitude a cycle; mul_p is the signed partial
  // product at its limb position, subtraction folded into the sign.
  logic signed [WW-1:0] mul_a;
  logic signed [ELEM_W-1:0] mul_b;
  logic        mul_sub;
  logic [1:0]  mlast;                 // last limb of the current operand
  logic [WW-1:0] a_mag, pp_sh;
  logic [LW-1:0] a_limb, b_mag;
  logic [2*LW-1:0] mul_pp;
  logic        mul_neg;
  logic signed [WW-1:0] mul_p;

  // Index helpers for the current cofactor
  logic [1:0] sr, sc, r0, r1, r2, c_t, c_a, c_b;
  assign sr  = cidx_r[3:2];
  assign sc  = cidx_r[1:0];
  assign r0  = skip_idx(sr, 2'd0);
  assign r1  = skip_idx(sr, 2'd1);
  assign r2  = skip_idx(sr, 2'd2);
  assign c_t = skip_idx(sc, term_r);
  // columns of the 2x2 minor: the two minor columns other than term_r
  assign c_a = skip_idx(sc, (term_r == 2'd0) ? 2'd1 : 2'd0);
  assign c_b = skip_idx(sc, (term_r == 2'd2) ? 2'd1 : 2'd2);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sub = 1'b0;
    mlast   = 2'd0;
    case (state_r)
      S_COF_M: begin
        // element times element: one limb
        if (mstep_r == 2'd0) begin
          mul_a = WW'(mat_r[{r1, c_a}]);
          mul_b = mat_r[{r2, c_b}];
        end else begin
          mul_a   = WW'(mat_r[{r1, c_b}]);
          mul_b   = mat_r[{r2, c_a}];
          mul_sub = 1'b1;
        end
      end
      S_COF_S: begin
        // 2x2 minor magnitude fits two limbs
        mul_a   = minor_r;
        mul_b   = mat_r[{r0, c_t}];
        mul_sub = (term_r == 2'd1);
        mlast   = 2'd1;
      end
      S_DET: begin
        // cofactor magnitude fits three limbs
        mul_a = cof_r[{2'd0, term_r}];
        mul_b = mat_r[{2'd0, term_r}];
        mlast = 2'd2;
      end
      default: ;
    endcase
  end

  assign a_mag   = mul_a[WW-1] ? WW'(-mul_a) : WW'(mul_a);
  assign a_limb  = a_mag[{mlimb_r, 5'd0} +: LW];
  assign b_mag   = mul_b[ELEM_W-1] ? LW'(-mul_b) : LW'(mul_b);
  assign mul_pp  = {{LW{1'b0}}, a_limb} * {{LW{1'b0}}, b_mag};
  assign pp_sh   = WW'(mul_pp) << {mlimb_r, 5'd0};
  assign mul_neg = mul_a[WW-1] ^ mul_b[ELEM_W-1] ^ mul_sub;
  assign mul_p   = mul_neg ? -pp_sh : pp_sh;

  // Divider trial subtract
  logic [WW-1:0] rem_sh, rem_sub;
  logic          rem_ge;
  assign rem_sh  = {rem_r[WW-2:0], dmag_r[WW-1]};
  assign rem_ge  = rem_sh >= det_r;
  assign rem_sub = rem_sh - det_r;

  logic [WW-1:0] thr_w, rnd_sh;
  assign thr_w  = WW'(thr_r) << (3*FRAC_BITS);
  assign rnd_sh = {rem_r[WW-2:0], 1'b0};

  logic [WW-1:0] num_mag;
  assign num_mag = cof_r[{ocol_r, orow_r}][WW-1]
                 ? WW'(-cof_r[{ocol_r, orow_r}]) : WW'(cof_r[{ocol_r, orow_r}]);

  logic [WW-1:0] qf;
  logic [ELEM_W-1:0] sat_v;
  always_comb begin
    qf = qt_r + WW'(rnd_sh >= det_r);
    if (dneg_r) begin
      if (qf > WW'(33'h80000000)) sat_v = 32'h80000000;
      else sat_v = ELEM_W'(-qf);
    end else begin
      if (qf > WW'(32'h7FFFFFFF)) sat_v = 32'h7FFFFFFF;
      else sat_v = qf[ELEM_W-1:0];
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_EMIT);
  assign out_inv_x = rowbuf_r[0];
  assign out_inv_y = rowbuf_r[1];
  assign out_inv_z = rowbuf_r[2];
  assign out_inv_w = rowbuf_r[3];
  assign out_singular = sing_r;
  assign out_last_row = (orow_r == 2'd3);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      row_cnt_r <= '0;
      thr_r     <= THR_RESET;
      cidx_r    <= '0;
      term_r    <= '0;
      mstep_r   <= '0;
      mlimb_r   <= '0;
      orow_r    <= '0;
      ocol_r    <= '0;
    end else begin
      if (cfg_valid) thr_r <= cfg_data;
      case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            mat_r[{row_cnt_r, 2'd0}] <= in_elem_x;
            mat_r[{row_cnt_r, 2'd1}] <= in_elem_y;
            mat_r[{row_cnt_r, 2'd2}] <= in_elem_z;
            mat_r[{row_cnt_r, 2'd3}] <= in_elem_w;
            if (in_final_row) begin
              row_cnt_r <= '0;
              cidx_r    <= '0;
              term_r    <= '0;
              mstep_r   <= '0;
              mlimb_r   <= '0;
              acc_r     <= '0;
              state_r   <= S_COF_M;
            end else begin
              row_cnt_r <= row_cnt_r + 2'd1;
            end
          end
        end
        S_COF_M: begin
          if (mstep_r == 2'd0) begin
            minor_r <= mul_p;
            mstep_r <= 2'd1;
          end else begin
            minor_r <= minor_r + mul_p;
            mstep_r <= 2'd0;
            state_r <= S_COF_S;
          end
        end
        S_COF_S: begin
          acc_r <= acc_r + mul_p;
          if (mlimb_r != mlast) begin
            mlimb_r <= mlimb_r + 2'd1;
          end else begin
            mlimb_r <= '0;
            if (term_r == 2'd2) begin
              term_r  <= '0;
              state_r <= S_COF_N;
            end else begin
              term_r  <= term_r + 2'd1;
              state_r <= S_COF_M;
            end
          end
        end
        S_COF_N: begin
          cof_r[cidx_r] <= (sr[0] ^ sc[0]) ? -acc_r : acc_r;
          acc_r <= '0;
          if (cidx_r == 4'd15) begin
            term_r  <= '0;
            state_r <= S_DET;
          end else begin
            cidx_r  <= cidx_r + 4'd1;
            state_r <= S_COF_M;
          end
        end
        S_DET: begin
          acc_r <= acc_r + mul_p;
          if (mlimb_r != mlast) begin
            mlimb_r <= mlimb_r + 2'd1;
          end else begin
            mlimb_r <= '0;
            if (term_r == 2'd3) state_r <= S_THR;
            term_r <= term_r + 2'd1;
          end
        end
        S_THR: begin
          det_r  <= acc_r[WW-1] ? -acc_r : acc_r;
          sing_r <= (acc_r[WW-1] ? WW'(-acc_r) : WW'(acc_r)) <= thr_w;
          orow_r <= '0;
          ocol_r <= '0;
          state_r <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          dneg_r <= cof_r[{ocol_r, orow_r}][WW-1];
          dmag_r <= num_mag << (2*FRAC_BITS);
          rem_r  <= '0;
          qt_r   <= '0;
          bit_r  <= '0;
          if (sing_r) begin
            rowbuf_r[ocol_r] <= '0;
            ocol_r <= ocol_r + 2'd1;
            if (ocol_r == 2'd3) state_r <= S_EMIT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_ge ? rem_sub : rem_sh;
          qt_r   <= {qt_r[WW-2:0], rem_ge};
          dmag_r <= {dmag_r[WW-2:0], 1'b0};
          bit_r  <= bit_r + QCW'(1);
          if (bit_r == QCW'(QB - 1)) state_r <= S_DIV_RND;
        end
        S_DIV_RND: begin
          rowbuf_r[ocol_r] <= sat_v;
          ocol_r <= ocol_r + 2'd1;
          state_r <= (ocol_r == 2'd3) ? S_EMIT : S_DIV_INIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            orow_r <= orow_r + 2'd1;
            state_r <= (orow_r == 2'd3) ? S_LOAD : S_DIV_INIT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench for matrix4_inverse: random and directed 4x4 matrices, checked
// against an exact wide-integer adjugate predictor held here.
// Depends on m4inv_pkg, m4inv_if and matrix4_inverse from the RTL.
`timescale 1ns / 100ps

module tb_top
  import m4inv_pkg::*;
();

  localparam int FRAC     = FRAC_BITS_DF;
  localparam int WDOG_MAX = 40000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] EMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] EMIN = 32'sh8000_0000;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic signed [31:0] x, y, z, w;
    logic               final_row;
  } row_req_t;

  typedef struct packed {
    logic signed [31:0] x, y, z, w;
    logic               singular;
    logic               last_row;
  } inv_row_t;

  logic clk = 1'b0;
  logic rst_n;

  m4inv_if #(.payload_t(row_req_t))   row_ch (clk);
  m4inv_if #(.payload_t(inv_row_t))   inv_ch (clk);
  m4inv_if #(.payload_t(logic [15:0])) thr_ch (clk);

  matrix4_inverse i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (row_ch.valid),
    .in_ready     (row_ch.ready),
    .in_elem_x    (row_ch.data.x),
    .in_elem_y    (row_ch.data.y),
    .in_elem_z    (row_ch.data.z),
    .in_elem_w    (row_ch.data.w),
    .in_final_row (row_ch.data.final_row),
    .out_valid    (inv_ch.valid),
    .out_ready    (inv_ch.ready),
    .out_inv_x    (inv_ch.data.x),
    .out_inv_y    (inv_ch.data.y),
    .out_inv_z    (inv_ch.data.z),
    .out_inv_w    (inv_ch.data.w),
    .out_singular (inv_ch.data.singular),
    .out_last_row (inv_ch.data.last_row),
    .cfg_valid    (thr_ch.valid),
    .cfg_ready    (thr_ch.ready),
    .cfg_data     (thr_ch.data)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic signed [31:0] mat_copy [16];
  logic [1:0]         slot_copy;
  logic [15:0]        thr_copy;

  row_req_t row_pending [$];
  inv_row_t inv_expected [$];
  int       fail_cnt = 0;
  bit       calm_mode = 1'b0;

  // Mostly short gaps, a few long ones; calm stretches have none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 120);
  endfunction

  // Signed cofactor of (sr, sc), exact
  function automatic wide_t cofactor_of(int sr, int sc);
    int    rr[3], cc[3];
    int    n;
    wide_t a[3][3];
    wide_t r;
    n = 0;
    for (int i = 0; i < 4; i++) if (i != sr) begin rr[n] = i; n++; end
    n = 0;
    for (int i = 0; i < 4; i++) if (i != sc) begin cc[n] = i; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = mat_copy[rr[i]*4 + cc[j]];
    r = a[0][0] * (a[1][1]*a[2][2] - a[1][2]*a[2][1])
      - a[0][1] * (a[1][0]*a[2][2] - a[1][2]*a[2][0])
      + a[0][2] * (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
    if ((sr + sc) % 2 != 0) r = -r;
    return r;
  endfunction

  // round(cof * 2^2F / |det|), half away from zero, saturated
  function automatic logic signed [31:0] scale_elem(wide_t cof, wide_t dmag);
    logic [191:0] num, q, rm;
    bit           neg;
    neg = cof < 0;
    num = neg ? -cof : cof;
    num = num << (2*FRAC);
    q   = num / dmag;
    rm  = num % dmag;
    if ((rm << 1) >= dmag) q = q + 1;
    if (neg) return (q >= 192'h8000_0000) ? EMIN : -$signed(q[31:0]);
    return (q > 192'h7fff_ffff) ? EMAX : q[31:0];
  endfunction

  // Store the accepted row; on the marked row, push the four inverse rows
  task automatic take_row(row_req_t rq);
    wide_t    cof [4][4];
    wide_t    det;
    bit       sing;
    inv_row_t o;
    mat_copy[slot_copy*4 + 0] = rq.x;
    mat_copy[slot_copy*4 + 1] = rq.y;
    mat_copy[slot_copy*4 + 2] = rq.z;
    mat_copy[slot_copy*4 + 3] = rq.w;
    if (!rq.final_row) begin
      slot_copy = slot_copy + 2'd1;
      return;
    end
    slot_copy = 2'd0;
    det = 0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) cof[r][c] = cofactor_of(r, c);
    for (int c = 0; c < 4; c++) det = det + wide_t'(mat_copy[c]) * cof[0][c];
    if (det < 0) det = -det;
    sing = det <= (wide_t'(thr_copy) << (3*FRAC));
    for (int r = 0; r < 4; r++) begin
      o.x = sing ? '0 : scale_elem(cof[0][r], det);
      o.y = sing ? '0 : scale_elem(cof[1][r], det);
      o.z = sing ? '0 : scale_elem(cof[2][r], det);
      o.w = sing ? '0 : scale_elem(cof[3][r], det);
      o.singular = sing;
      o.last_row = (r == 3);
      inv_expected.push_back(o);
    end
  endtask

  // Row driver
  int row_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      row_ch.valid <= 1'b0;
    end else if (!row_ch.valid || row_ch.ready) begin
      if (row_ch.valid) take_row(row_ch.data);
      if (row_gap > 0) begin
        row_gap <= row_gap - 1;
        row_ch.valid <= 1'b0;
      end else if (row_pending.size() > 0) begin
        row_ch.data  <= row_pending.pop_front();
        row_ch.valid <= 1'b1;
        row_gap      <= pick_gap();
      end else begin
        row_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  int rdy_gap = 0;
  always @(posedge clk) begin
    inv_row_t exp_row;
    if (!rst_n) begin
      inv_ch.ready <= 1'b0;
    end else begin
      if (inv_ch.valid && inv_ch.ready) begin
        if (inv_expected.size() == 0) begin
          $display("%0t unexpected inverse row: actual %h", $time, inv_ch.data);
          fail_cnt++;
        end else begin
          exp_row = inv_expected.pop_front();
          if (inv_ch.data.x !== exp_row.x || inv_ch.data.y !== exp_row.y ||
              inv_ch.data.z !== exp_row.z || inv_ch.data.w !== exp_row.w ||
              inv_ch.data.singular !== exp_row.singular ||
              inv_ch.data.last_row !== exp_row.last_row) begin
            $display({"%0t inverse row mismatch: expected %h %h %h %h s%b l%b",
                      " actual %h %h %h %h s%b l%b"},
                     $time, exp_row.x, exp_row.y, exp_row.z, exp_row.w,
                     exp_row.singular, exp_row.last_row,
                     inv_ch.data.x, inv_ch.data.y, inv_ch.data.z, inv_ch.data.w,
                     inv_ch.data.singular, inv_ch.data.last_row);
            fail_cnt++;
          end
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap      <= rdy_gap - 1;
        inv_ch.ready <= 1'b0;
      end else begin
        inv_ch.ready <= 1'b1;
        rdy_gap      <= pick_gap();
      end
    end
  end

  // Watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (row_ch.valid && row_ch.ready) || (inv_ch.valid && inv_ch.ready) ||
        (thr_ch.valid && thr_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [31:0] rand_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 85) return $signed($urandom_range(0, 8*65536)) - 4*65536;
    if (r < 90) return EMAX;
    if (r < 95) return EMIN;
    return $signed($urandom_range(0, 2)) - 1;
  endfunction

  task automatic push_row(logic signed [31:0] x, y, z, w, logic fin);
    row_req_t rq;
    rq = '{x: x, y: y, z: z, w: w, final_row: fin};
    row_pending.push_back(rq);
  endtask

  task automatic push_diag(logic signed [31:0] a, b, c, d);
    push_row(a, 0, 0, 0, 1'b0);
    push_row(0, b, 0, 0, 1'b0);
    push_row(0, 0, c, 0, 1'b0);
    push_row(0, 0, 0, d, 1'b1);
  endtask

  // Random matrices: mostly full sets, some early marks, some wraps
  task automatic push_random(int n_items);
    int sent, k, rows;
    logic signed [31:0] r0 [4];
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 99);
      rows = (k < 80) ? 4 : (k < 90) ? $urandom_range(1, 3) : 6;
      for (int i = 0; i < rows; i++) begin
        if (i == 0) foreach (r0[j]) r0[j] = rand_elem();
        // occasional repeated row makes the matrix exactly singular
        if (i == 3 && $urandom_range(0, 9) == 0)
          push_row(r0[0], r0[1], r0[2], r0[3], 1'b1);
        else if (i == 0)
          push_row(r0[0], r0[1], r0[2], r0[3], rows == 1);
        else
          push_row(rand_elem(), rand_elem(), rand_elem(), rand_elem(), i == rows - 1);
      end
      sent += rows;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (row_pending.size() != 0 || row_ch.valid || inv_expected.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    thr_ch.valid <= 1'b1;
    thr_ch.data  <= v;
    do @(posedge clk);
    while (!thr_ch.ready);
    thr_ch.valid <= 1'b0;
    thr_copy = v;
  endtask

  initial begin
    rst_n = 1'b0;
    row_ch.valid = 1'b0;
    row_ch.data  = '0;
    inv_ch.ready = 1'b0;
    thr_ch.valid = 1'b0;
    thr_ch.data  = '0;
    thr_copy  = THR_RESET;
    slot_copy = 2'd0;
    foreach (mat_copy[i]) mat_copy[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, scaled, extremes, singular, early mark, wrap
    write_threshold(16'd1);
    push_diag(ONE, ONE, ONE, ONE);
    push_diag(EMIN, ONE, ONE, 32'sh0000_0100);
    push_diag(ONE, ONE, ONE, 32'sd1);
    push_row(EMAX, EMAX, EMAX, EMAX, 1'b0);
    push_row(EMIN, EMIN, EMIN, EMIN, 1'b0);
    push_row(0, 0, 0, 0, 1'b0);
    push_row(-ONE, ONE, EMAX, EMIN, 1'b1);
    push_row(2*ONE, -ONE, 0, ONE, 1'b1);
    push_row(ONE, 3*ONE, -2*ONE, 0, 1'b0);
    push_row(0, ONE, ONE, -ONE, 1'b0);
    push_row(ONE, 0, ONE, 0, 1'b0);
    push_row(-ONE, 2*ONE, 0, ONE, 1'b0);
    push_row(0, 0, 5*ONE, ONE, 1'b0);
    push_row(3*ONE, ONE, 0, -ONE, 1'b1);
    wait_idle();

    // Threshold 0: only an exact zero determinant is singular
    write_threshold(16'd0);
    push_diag(ONE, ONE, ONE, 32'sd1);
    push_diag(ONE, 0, ONE, ONE);
    calm_mode = 1'b1;
    push_random(40);
    wait_idle();
    calm_mode = 1'b0;
    push_random(40);
    wait_idle();

    write_threshold(16'hffff);
    push_diag(ONE, ONE, ONE, ONE);
    push_random(70);
    wait_idle();

    write_threshold($urandom_range(2, 65534));
    push_random(70);
    wait_idle();

    write_threshold(16'd1);
    push_random(80);
    wait_idle();
    repeat (100) @(posedge clk);

    if (fail_cnt == 0 && inv_expected.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
